>>> rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define STSWS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the trigger holds, the result must hold in the next cycle.
`define STSWS_ASSERT_NEXT(lbl, trig, res, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (res)) \
        else $error(msg);

`endif

>>> rtl/stsws_pkg.sv
package stsws_pkg;

    // Widest supported number of split passes; child indexes are carried at this width.
    localparam int MAX_PASSES = 6;
    localparam int CHILD_W = MAX_PASSES;
    localparam int SPLIT_PASSES_DEF = 4;

    // Ninety degrees in units of 2^-20 degree.
    localparam logic [27:0] DEG90 = 28'd94371840;

    // Degrees to radians in Q40, cut into a high and a low part for two narrow multipliers.
    localparam logic [35:0] RAD_Q40 = 36'd19190098069;
    localparam logic [16:0] RAD_HI = 17'(RAD_Q40 >> 18);
    localparam logic [17:0] RAD_LO = 18'(RAD_Q40 & 36'h3FFFF);

    // Reciprocals for exact 32-bit division by a constant: q = (n * M) >> (32 + L).
    localparam logic [32:0] M90 = 33'(((64'd1 << 39) + 64'd89) / 64'd90);
    localparam int L90 = 7;
    localparam logic [32:0] STEP_M [3] = '{
        33'(((64'd1 << 38) + 64'd55) / 64'd56),
        33'(((64'd1 << 37) + 64'd29) / 64'd30),
        33'(((64'd1 << 36) + 64'd11) / 64'd12)
    };
    localparam int STEP_L [3] = '{6, 5, 4};

    // One input box.
    typedef struct packed {
        logic        [28:0] ra_low;
        logic        [28:0] ra_high;
        logic signed [27:0] dec_low;
        logic signed [27:0] dec_high;
    } t_box_in;

    // One child box.
    typedef struct packed {
        logic        [28:0] child_ra_low;
        logic        [28:0] child_ra_high;
        logic signed [27:0] child_dec_low;
        logic signed [27:0] child_dec_high;
        logic        [3:0]  child_number;
        logic               last_child;
    } t_child_out;

    // A box on its way down the split chain, with its final child position.
    typedef struct packed {
        t_box_in            box;
        logic [CHILD_W-1:0] idx;
        logic               last;
    } t_item;

    // Per-stage context inside one split unit.
    typedef struct packed {
        t_item              item;
        logic               hi;
        logic        [28:0] rmid;
        logic signed [27:0] dmid;
        logic signed [28:0] dspan;
        logic signed [29:0] rspan;
        logic        [27:0] a;
        logic               a_big;
        logic        [31:0] x2;
    } t_ctx;

endpackage

>>> rtl/stsws_split.sv
module stsws_split #(
    parameter int PASSES = 4,
    parameter int LEVEL  = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  stsws_pkg::t_item i_item,
    output logic           o_valid,
    output stsws_pkg::t_item o_item
);
    import stsws_pkg::*;

    localparam int NST = 19;

    logic [NST-1:0] r_v;
    t_ctx           r_ctx [NST-1];
    t_ctx           n_ctx0;
    t_ctx           n_ctx4;
    logic [45:0]    r_pl;
    logic [44:0]    r_ph;
    logic [31:0]    r_x;
    logic [63:0]    r_xx;
    logic [64:0]    r_p90;
    logic [30:0]    r_t0;
    logic [62:0]    r_pr [3];
    logic [64:0]    r_mm [3];
    logic [30:0]    r_ts [3];
    logic [62:0]    r_prf;
    logic [16:0]    r_c;
    logic signed [47:0] r_rhs;
    t_item          r_out;
    logic [63:0]    n_xs;
    logic [31:0]    n_qf;
    logic signed [33:0] n_tf;
    logic [33:0]    n_cr;
    logic [16:0]    n_c;
    logic signed [47:0] n_lhs;
    t_item          n_out;

    // Valid bits move with the data whenever the chain advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // Midpoints, spans and the absolute mid-Dec.
    always_comb begin
        logic signed [28:0] dsum;
        logic        [29:0] rsum;
        dsum = 29'(i_item.box.dec_low) + 29'(i_item.box.dec_high);
        rsum = 30'(i_item.box.ra_low) + 30'(i_item.box.ra_high);
        n_ctx0       = '0;
        n_ctx0.item  = i_item;
        n_ctx0.hi    = i_item.idx[PASSES-1-LEVEL];
        n_ctx0.rmid  = rsum[29:1];
        // Truncate toward zero: add one before the shift when negative.
        n_ctx0.dmid  = 28'((dsum + 29'(dsum[28])) >>> 1);
        n_ctx0.dspan = 29'(i_item.box.dec_high) - 29'(i_item.box.dec_low);
        n_ctx0.rspan = $signed({1'b0, i_item.box.ra_high}) - $signed({1'b0, i_item.box.ra_low});
        n_ctx0.a     = n_ctx0.dmid[27] ? 28'(-n_ctx0.dmid) : 28'(n_ctx0.dmid);
        n_ctx0.a_big = (n_ctx0.a >= DEG90);
    end

    // Radians from the two partial products, and x squared into the context.
    always_comb begin
        n_xs = {1'b0, r_ph, 18'b0} + 64'(r_pl);
        n_ctx4 = r_ctx[3];
        n_ctx4.x2 = r_xx[61:30];
    end

    // Last series step, clamp and rounding to Q1.16.
    always_comb begin
        n_qf = r_prf[61:30];
        n_tf = (34'sd1 <<< 30) - $signed({3'b0, n_qf[31:1]});
        if (n_tf < 0) begin
            n_cr = '0;
        end else begin
            n_cr = (34'(n_tf) + 34'd8192) >> 14;
        end
        if (r_ctx[15].a_big) begin
            n_c = '0;
        end else if (n_cr > 34'd65536) begin
            n_c = 17'd65536;
        end else begin
            n_c = 17'(n_cr);
        end
    end

    // Choose the cut and form the selected half.
    always_comb begin
        n_lhs = 48'(r_ctx[17].dspan) <<< 16;
        n_out = r_ctx[17].item;
        if (n_lhs < r_rhs) begin
            if (r_ctx[17].hi) begin
                n_out.box.ra_low = r_ctx[17].rmid;
            end else begin
                n_out.box.ra_high = r_ctx[17].rmid;
            end
        end else begin
            if (r_ctx[17].hi) begin
                n_out.box.dec_low = r_ctx[17].dmid;
            end else begin
                n_out.box.dec_high = r_ctx[17].dmid;
            end
        end
    end

    // Fixed stages of the datapath.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= n_ctx0;
            for (int j = 1; j < NST - 1; j++) begin
                if (j == 4) begin
                    r_ctx[j] <= n_ctx4;
                end else begin
                    r_ctx[j] <= r_ctx[j-1];
                end
            end
            r_pl  <= 46'(r_ctx[0].a) * 46'(RAD_LO);
            r_ph  <= 45'(r_ctx[0].a) * 45'(RAD_HI);
            r_x   <= n_xs[61:30];
            r_xx  <= 64'(r_x) * 64'(r_x);
            r_p90 <= 65'(r_xx[61:30]) * 65'(M90);
            r_t0  <= 31'(33'h40000000 - 33'(r_p90 >> (32 + L90)));
            r_prf <= 63'(r_ctx[14].x2) * 63'(r_ts[2]);
            r_c   <= n_c;
            r_rhs <= 48'(r_ctx[16].rspan) * $signed({31'b0, r_c});
            r_out <= n_out;
        end
    end

    // Middle series steps: multiply, divide by a constant, subtract from one.
    for (genvar s = 0; s < 3; s++) begin : g_step
        logic [30:0] n_tin;
        if (s == 0) begin : g_first
            assign n_tin = r_t0;
        end else begin : g_next
            assign n_tin = r_ts[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pr[s] <= 63'(r_ctx[5+3*s].x2) * 63'(n_tin);
                r_mm[s] <= 65'(r_pr[s][61:30]) * 65'(STEP_M[s]);
                r_ts[s] <= 31'(33'h40000000 - 33'(r_mm[s] >> (32 + STEP_L[s])));
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_item  = r_out;

endmodule

>>> rtl/sky_tile_sixteen_way_split.sv
// Channel  Direction  Signals                              Word
// box      in         i_in_valid, o_in_ready, i_box        one sky box
// child    out        o_out_valid, i_out_ready, o_child    one child box
//
// Each box gives 2^SPLIT_PASSES children, one issued per unstalled cycle. The box
// is held while its children are issued, and a new box is taken only after the last
// child of the one before has been issued.
// Each child word passes through the registers of one split unit per split pass.
// Reset is synchronous and clears the valid bits and the issue state.
// A stall on the output freezes the whole chain; nothing is lost or repeated.
module sky_tile_sixteen_way_split #(
    parameter int SPLIT_PASSES = stsws_pkg::SPLIT_PASSES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  stsws_pkg::t_box_in    i_box,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output stsws_pkg::t_child_out o_child
);
    import stsws_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = SPLIT_PASSES;
    localparam logic [CW-1:0] LAST_IDX = {CW{1'b1}};

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    t_box_in       r_box;
    logic          w_en;
    logic          w_issue;
    t_item         w_item;
    logic          w_v   [SPLIT_PASSES+1];
    t_item         w_it  [SPLIT_PASSES+1];

    // The chain advances unless a finished word is held back.
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_busy;
    assign w_issue    = r_busy && w_en;

    // Hold the box and count out its children.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_in_valid && o_in_ready) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_issue) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_box <= i_box;
        end
    end

    always_comb begin
        w_item      = '0;
        w_item.box  = r_box;
        w_item.idx  = CHILD_W'(r_cnt);
        w_item.last = (r_cnt == LAST_IDX);
    end

    assign w_v[0]  = w_issue;
    assign w_it[0] = w_item;

    // One split unit per pass.
    for (genvar p = 0; p < SPLIT_PASSES; p++) begin : g_pass
        stsws_split #(
            .PASSES (SPLIT_PASSES),
            .LEVEL  (p)
        ) u_split (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[p]),
            .i_item  (w_it[p]),
            .o_valid (w_v[p+1]),
            .o_item  (w_it[p+1])
        );
    end

    // Output word from the last unit's final register.
    assign o_out_valid = w_v[SPLIT_PASSES];
    always_comb begin
        o_child.child_ra_low   = w_it[SPLIT_PASSES].box.ra_low;
        o_child.child_ra_high  = w_it[SPLIT_PASSES].box.ra_high;
        o_child.child_dec_low  = w_it[SPLIT_PASSES].box.dec_low;
        o_child.child_dec_high = w_it[SPLIT_PASSES].box.dec_high;
        o_child.child_number   = w_it[SPLIT_PASSES].idx[3:0];
        o_child.last_child     = w_it[SPLIT_PASSES].last;
    end

    // Checks on the issue logic and on the last-child flag of the output.
    `STSWS_ASSERT_NEXT(a_start, i_in_valid && o_in_ready, r_busy && (r_cnt == '0), "box accept did not start issue")
    `STSWS_ASSERT_NEXT(a_done, w_issue && (r_cnt == LAST_IDX), !r_busy, "issue did not end after last child")
    `STSWS_ASSERT(a_last, !(o_out_valid && o_child.last_child) || (o_child.child_number == 4'(LAST_IDX)), "last child has wrong number")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import stsws_pkg::*;

    localparam longint DEG90_L  = 64'sd94371840;
    localparam longint RAD_Q40  = 64'sd19190098069;
    localparam longint ONE_Q30  = 64'sd1 << 30;
    localparam int     N_CHILD  = 16;
    localparam int     N_RANDOM = 250;
    localparam int     IDLE_LIMIT = 4000;
    localparam logic [28:0] RA_MAX  = 29'd377487360;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_box_in    i_box;
    logic       o_out_valid;
    logic       i_out_ready;
    t_child_out o_child;

    // Boxes waiting to be sent, with a flag that makes the sender wait for a drain.
    t_box_in    pending_boxes[$];
    bit         drain_first[$];
    t_child_out expected_children[$];

    int  send_gap;
    int  recv_stall;
    bit  burst_mode;
    int  idle_cycles;
    int  errors;
    int  boxes_sent;
    int  children_seen;
    int  drains_done;

    sky_tile_sixteen_way_split u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_box      (i_box),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_child    (o_child)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cosine of a Dec angle in Q1.16, by a truncated Taylor series in Q30.
    function automatic longint cos_q16(longint dec);
        longint a;
        longint x;
        longint x2;
        longint t;
        longint c;
        longint divs[4];
        divs = '{56, 30, 12, 2};
        a = (dec < 0) ? -dec : dec;
        if (a >= DEG90_L) return 0;
        x  = (a * RAD_Q40) >>> 30;
        x2 = (x * x) >>> 30;
        t  = ONE_Q30 - x2 / 90;
        for (int k = 0; k < 4; k++) begin
            t = ONE_Q30 - ((x2 * t) >>> 30) / divs[k];
        end
        if (t < 0) t = 0;
        c = (t + 8192) >>> 14;
        if (c > 65536) c = 65536;
        return c;
    endfunction

    // Splits one box four times and queues its sixteen children in tree order.
    task automatic predict_children(input t_box_in b);
        longint rlo[N_CHILD];
        longint rhi[N_CHILD];
        longint dlo[N_CHILD];
        longint dhi[N_CHILD];
        longint rmid;
        longint dmid;
        longint c;
        int     n;
        t_child_out ch;
        rlo[0] = longint'(b.ra_low);
        rhi[0] = longint'(b.ra_high);
        dlo[0] = longint'($signed(b.dec_low));
        dhi[0] = longint'($signed(b.dec_high));
        n = 1;
        for (int pass = 0; pass < 4; pass++) begin
            // Descending order lets the children overwrite their parents in place.
            for (int i = n - 1; i >= 0; i--) begin
                rmid = (rlo[i] + rhi[i]) / 2;
                dmid = (dlo[i] + dhi[i]) / 2;
                c = cos_q16(dmid);
                rlo[2*i+1] = rlo[i]; rhi[2*i+1] = rhi[i];
                dlo[2*i+1] = dlo[i]; dhi[2*i+1] = dhi[i];
                rlo[2*i]   = rlo[i]; rhi[2*i]   = rhi[i];
                dlo[2*i]   = dlo[i]; dhi[2*i]   = dhi[i];
                if ((dhi[i] - dlo[i]) * 65536 < (rhi[i] - rlo[i]) * c) begin
                    rhi[2*i]   = rmid;
                    rlo[2*i+1] = rmid;
                end else begin
                    dhi[2*i]   = dmid;
                    dlo[2*i+1] = dmid;
                end
            end
            n = n * 2;
        end
        for (int k = 0; k < N_CHILD; k++) begin
            ch.child_ra_low   = 29'(rlo[k]);
            ch.child_ra_high  = 29'(rhi[k]);
            ch.child_dec_low  = 28'(dlo[k]);
            ch.child_dec_high = 28'(dhi[k]);
            ch.child_number   = 4'(k);
            ch.last_child     = (k == N_CHILD - 1);
            expected_children.push_back(ch);
        end
    endtask

    // Compares one child word with the oldest expected child.
    task automatic check_child(input t_child_out got);
        t_child_out exp_ch;
        if (expected_children.size() == 0) begin
            $display("%0t: unexpected child word %h", $time, got);
            errors++;
            return;
        end
        exp_ch = expected_children.pop_front();
        if (got.child_ra_low !== exp_ch.child_ra_low) begin
            $display("%0t: child_ra_low expected %0d actual %0d", $time,
                     exp_ch.child_ra_low, got.child_ra_low);
            errors++;
        end
        if (got.child_ra_high !== exp_ch.child_ra_high) begin
            $display("%0t: child_ra_high expected %0d actual %0d", $time,
                     exp_ch.child_ra_high, got.child_ra_high);
            errors++;
        end
        if (got.child_dec_low !== exp_ch.child_dec_low) begin
            $display("%0t: child_dec_low expected %0d actual %0d", $time,
                     exp_ch.child_dec_low, got.child_dec_low);
            errors++;
        end
        if (got.child_dec_high !== exp_ch.child_dec_high) begin
            $display("%0t: child_dec_high expected %0d actual %0d", $time,
                     exp_ch.child_dec_high, got.child_dec_high);
            errors++;
        end
        if (got.child_number !== exp_ch.child_number) begin
            $display("%0t: child_number expected %0d actual %0d", $time,
                     exp_ch.child_number, got.child_number);
            errors++;
        end
        if (got.last_child !== exp_ch.last_child) begin
            $display("%0t: last_child expected %0d actual %0d", $time,
                     exp_ch.last_child, got.last_child);
            errors++;
        end
    endtask

    // Draws a gap; burst phases send back to back.
    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic add_box(input logic [28:0] rl, input logic [28:0] rh,
                           input logic [27:0] dl, input logic [27:0] dh, input bit drain);
        t_box_in b;
        b.ra_low   = rl;
        b.ra_high  = rh;
        b.dec_low  = dl;
        b.dec_high = dh;
        pending_boxes.push_back(b);
        drain_first.push_back(drain);
    endtask

    // Sender: loads the next box word when its gap has run out and any drain it asks for is done.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_box      <= '0;
            send_gap    = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_children(i_box);
                boxes_sent++;
                if (boxes_sent % 40 == 0) burst_mode = ~burst_mode;
                send_gap = draw_gap();
            end
            if (!(i_in_valid && o_in_ready) && i_in_valid) begin
                // Still waiting for acceptance; hold the word.
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap    = send_gap - 1;
            end else if (pending_boxes.size() > 0 &&
                         !(drain_first[0] && expected_children.size() > 0)) begin
                if (drain_first[0]) drains_done++;
                i_box      <= pending_boxes.pop_front();
                void'(drain_first.pop_front());
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each child word and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall   = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_child(o_child);
                children_seen++;
                recv_stall = burst_mode ? 0 : $urandom_range(0, 10);
            end
            if (recv_stall > 0) begin
                i_out_ready <= 1'b0;
                recv_stall   = recv_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d children still expected", $time,
                     expected_children.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [28:0] rl, rh;
        logic [27:0] dl, dh;
        i_rst_n <= 1'b0;
        errors = 0; boxes_sent = 0; children_seen = 0; drains_done = 0;
        burst_mode = 1'b0;

        // Directed boxes: full sky, extremes, inverted spans, beyond the poles.
        add_box(29'd0, RA_MAX, -28'sd94371840, 28'sd94371840, 1'b0);
        add_box(29'd0, 29'd0, 28'sd0, 28'sd0, 1'b0);
        add_box(RA_MAX, RA_MAX, 28'sd94371840, 28'sd94371840, 1'b0);
        add_box(RA_MAX, 29'd0, 28'sd94371840, -28'sd94371840, 1'b0);
        add_box(29'd0, RA_MAX, 28'sd94371840, -28'sd94371840, 1'b0);
        add_box(RA_MAX, 29'd0, -28'sd94371840, 28'sd94371840, 1'b0);
        add_box(29'h1FFFFFFF, 29'h1FFFFFFF, 28'h7FFFFFF, 28'h7FFFFFF, 1'b0);
        add_box(29'h1FFFFFFF, 29'd0, 28'h8000000, 28'h7FFFFFF, 1'b0);
        add_box(29'd0, 29'h1FFFFFFF, 28'h7FFFFFF, 28'h8000000, 1'b0);
        add_box(29'd0, 29'd1048576, 28'sd93323264, 28'sd94371840, 1'b0);
        add_box(29'd0, 29'd104857600, 28'sd92274688, 28'sd94371840, 1'b0);
        add_box(29'd0, 29'd1048576, 28'sd0, 28'sd1048576, 1'b1);
        add_box(29'd0, 29'd2097152, -28'sd1048576, 28'sd1048576, 1'b0);
        add_box(29'd1000, 29'd1016, -28'sd8, 28'sd8, 1'b0);
        add_box(29'd5, 29'd6, -28'sd1, 28'sd0, 1'b0);
        add_box(29'd0, RA_MAX, -28'sd94371840, -28'sd94371839, 1'b0);
        add_box(29'd0, RA_MAX, 28'sd94371840, 28'sd95000000, 1'b0);

        // Random boxes: mostly ordered in-range boxes, some raw bit patterns.
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                rl = $urandom_range(0, RA_MAX);
                rh = $urandom_range(rl, RA_MAX);
                if ($urandom_range(0, 3) == 0) rh = rl + $urandom_range(0, 4096);
                dl = 28'($signed($urandom_range(0, 188743680)) - 94371840);
                dh = 28'($signed(dl) + $urandom_range(0,
                         94371840 - $signed(dl)));
            end else begin
                rl = $urandom; rh = $urandom;
                dl = $urandom; dh = $urandom;
            end
            add_box(rl, rh, dl, dh, (n % 80) == 79);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_boxes.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_children.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Split %0d boxes into %0d checked children, %0d drain pauses.",
                 boxes_sent, children_seen, drains_done);
        if (errors == 0 && expected_children.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d children missing", errors,
                     expected_children.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/stsws_pkg.sv
rtl/stsws_split.sv
rtl/sky_tile_sixteen_way_split.sv
tb/sv/tb_top.sv
